>>> hdl/mjt_pkg.sv
// ----------------------------------------------------------------------------
// mjt_pkg: shared types and constants of the minimum-jerk evaluator
// fixed-point formats, register map codes, sideband structs and the
// saturation helpers used by the output stages
// ----------------------------------------------------------------------------
package mjt_pkg;

  // number of axes
  localparam int NAX = 3;

  // data and configuration widths
  localparam int DATA_W = 32;
  localparam int DUR_W  = 31;
  localparam int ADDR_W = 5;

  // normalized time format: Q0.30 magnitude, one extra bit to hold 1.0
  localparam int QS  = 30;
  localparam int S_W = QS + 1;
  localparam logic [S_W-1:0] ONE_QS = {1'b1, {QS{1'b0}}};

  // blend polynomial inner term 10 - 15 s + 6 s^2, split for two multipliers
  localparam int INNER_W  = 34;
  localparam int INNER_LO = 17;
  localparam int INNER_HI = INNER_W - INNER_LO;

  // position math width (start +/- 33-bit magnitude)
  localparam int PV_W = 35;
  localparam int PM_W = 33;

  // register indexes
  localparam logic [2:0] REG_START_X       = 3'd0;
  localparam logic [2:0] REG_START_Y       = 3'd1;
  localparam logic [2:0] REG_START_Z       = 3'd2;
  localparam logic [2:0] REG_END_X         = 3'd3;
  localparam logic [2:0] REG_END_Y         = 3'd4;
  localparam logic [2:0] REG_END_Z         = 3'd5;
  localparam logic [2:0] REG_MOVE_DURATION = 3'd6;

  // sideband through the time divider
  typedef struct packed {
    logic neg;
    logic eq;
  } sside_t;

  // sideband through the velocity dividers
  typedef struct packed {
    logic              ok;
    logic              ovf;
    logic [DATA_W-1:0] pos;
  } vside_t;

  // clamp a 35-bit two's complement value to 32 bits
  function automatic logic [DATA_W-1:0] sat_pos(input logic [PV_W-1:0] v);
    logic [3:0] top;
    top = v[PV_W-1:DATA_W-1];
    if (top == 4'b0000 || top == 4'b1111) begin
      return v[DATA_W-1:0];
    end else if (v[PV_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // apply sign to an unsigned velocity magnitude and saturate
  function automatic logic [DATA_W-1:0] sat_vel(input logic [DATA_W-1:0] mag,
                                                input logic ovf,
                                                input logic neg);
    logic [DATA_W-1:0] min_v;
    logic [DATA_W-1:0] max_v;
    min_v = {1'b1, {(DATA_W-1){1'b0}}};
    max_v = {1'b0, {(DATA_W-1){1'b1}}};
    if (neg) begin
      if (ovf || mag > min_v) begin
        return min_v;
      end
      return ~mag + {{(DATA_W-1){1'b0}}, 1'b1};
    end else begin
      if (ovf || mag[DATA_W-1]) begin
        return max_v;
      end
      return mag;
    end
  endfunction

endpackage

>>> hdl/mjt_div.sv
// ----------------------------------------------------------------------------
// mjt_div: pipelined restoring divider
// one quotient bit per stage; the partial remainder enters below the
// divisor and the numerator low bits are shifted in one per stage
// ----------------------------------------------------------------------------
module mjt_div #(
  parameter int DW = 31,
  parameter int QW = 30,
  parameter int SW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [SW-1:0] side_i,
  input  logic [DW-1:0] divisor_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [QW-1:0] vld_q;
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] num_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          src_vld;
    logic [DW-1:0] src_rem;
    logic [QW-1:0] src_num;
    logic [QW-1:0] src_quo;
    logic [SW-1:0] src_side;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [QW:0]   quo_ext;
    logic          ge;

    if (k == 0) begin : g_first
      assign src_vld  = valid_i;
      assign src_rem  = rem_i;
      assign src_num  = num_i;
      assign src_quo  = '0;
      assign src_side = side_i;
    end else begin : g_next
      assign src_vld  = vld_q[k-1];
      assign src_rem  = rem_q[k-1];
      assign src_num  = num_q[k-1];
      assign src_quo  = quo_q[k-1];
      assign src_side = side_q[k-1];
    end

    // shift in next numerator bit, subtract when it fits
    assign trial   = {src_rem, src_num[QW-1]};
    assign ge      = trial >= {1'b0, divisor_i};
    assign diff    = trial - {1'b0, divisor_i};
    assign quo_ext = {src_quo, ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_q[k]  <= {src_num[QW-2:0], 1'b0};
        quo_q[k]  <= quo_ext[QW-1:0];
        side_q[k] <= src_side;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

>>> hdl/min_jerk_trajectory_eval.sv
// ----------------------------------------------------------------------------
// min_jerk_trajectory_eval: three-axis minimum-jerk trajectory evaluator
// returns position and velocity of a quintic point-to-point move for
// each time sample, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   configure start point, end point and move duration over the APB port
//   (byte address 4*index) while no item is in flight. then send time
//   samples on the input channel (in_valid_i / in_stall_o); one result
//   item per sample comes out on the output channel (out_valid_o /
//   out_stall_i) in the same order.
//   the pipeline is one input stage, 30 stages for the normalized time
//   division t/T, eight stages of polynomial and per-axis multiply, 32
//   stages for the velocity division by T and one output register. the two
//   divisions, one bit per stage, set the depth.
//   throughput is one item per cycle while the output is not stalled.
//   when the receiver stalls, the output register holds its item; the
//   pipeline keeps moving and taking input until the last stage holds an
//   item too, then in_stall_o rises until the output drains.
//   reset empties the pipeline, clears start and end points to zero and
//   sets the duration to 1.0 in the time format (1 << FRAC_BITS).
// ----------------------------------------------------------------------------
module min_jerk_trajectory_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mjt_pkg::ADDR_W-1:0]  paddr,
  input  logic [mjt_pkg::DATA_W-1:0]  pwdata,
  output logic [mjt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          sample_time_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic signed [31:0]          pos_x_o,
  output logic signed [31:0]          pos_y_o,
  output logic signed [31:0]          pos_z_o,
  output logic signed [31:0]          vel_x_o,
  output logic signed [31:0]          vel_y_o,
  output logic signed [31:0]          vel_z_o
);

  import mjt_pkg::*;

  // velocity divisor is T scaled to the Q0.30 shape format
  localparam int VSH  = QS - FRAC_BITS;
  localparam int VDW  = DUR_W + VSH;
  localparam int VQW  = DATA_W;
  localparam int PP_W = DATA_W + S_W;
  localparam int PL_W = S_W + INNER_LO;
  localparam int PH_W = S_W + INNER_HI;
  localparam int NV_W = 2 * DATA_W;

  localparam logic [DUR_W-1:0] DUR_RST = {{(DUR_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [NV_W-1:0]  HALF_QS = {{(NV_W-1){1'b0}}, 1'b1} << (QS - 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] start_q [NAX];
  logic [DATA_W-1:0] end_q   [NAX];
  logic [DUR_W-1:0]  dur_q;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NAX; a++) begin
        start_q[a] <= '0;
        end_q[a]   <= '0;
      end
      dur_q <= DUR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_X:       start_q[0] <= pwdata;
        REG_START_Y:       start_q[1] <= pwdata;
        REG_START_Z:       start_q[2] <= pwdata;
        REG_END_X:         end_q[0]   <= pwdata;
        REG_END_Y:         end_q[1]   <= pwdata;
        REG_END_Z:         end_q[2]   <= pwdata;
        REG_MOVE_DURATION: dur_q      <= pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START_X:       prdata = start_q[0];
      REG_START_Y:       prdata = start_q[1];
      REG_START_Z:       prdata = start_q[2];
      REG_END_X:         prdata = end_q[0];
      REG_END_Y:         prdata = end_q[1];
      REG_END_Z:         prdata = end_q[2];
      REG_MOVE_DURATION: prdata = {1'b0, dur_q};
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // values derived from the configuration; the user, not the block, keeps them stable while items are in flight
  // --------------------------------------------------------------------------
  logic [DUR_W-1:0]  teff;      // zero duration acts as one lsb
  logic [VDW-1:0]    vdiv;      // T << (30 - FRAC_BITS)
  logic [DATA_W:0]   dax   [NAX];
  logic [DATA_W-1:0] mag_q [NAX];
  logic [NAX-1:0]    dneg_q;

  assign teff = (dur_q == '0) ? {{(DUR_W-1){1'b0}}, 1'b1} : dur_q;
  assign vdiv = {teff, {VSH{1'b0}}};

  for (genvar a = 0; a < NAX; a++) begin : g_delta
    // end - start as 33-bit signed
    assign dax[a] = {end_q[a][DATA_W-1], end_q[a]} - {start_q[a][DATA_W-1], start_q[a]};
  end

  // |end - start| and its sign, registered off the critical path
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NAX; a++) begin
      mag_q[a]  <= dax[a][DATA_W] ? DATA_W'(-dax[a]) : dax[a][DATA_W-1:0];
      dneg_q[a] <= dax[a][DATA_W];
    end
  end

  // --------------------------------------------------------------------------
  // flow control: the whole pipe advances unless the output register is
  // held and the last stage already has an item waiting behind it
  // --------------------------------------------------------------------------
  logic adv;
  logic out_take;
  logic last_vld;
  logic out_valid_q;

  assign out_take   = ~out_valid_q | ~out_stall_i;
  assign adv        = out_take | ~last_vld;
  assign in_stall_o = ~adv;

  // --------------------------------------------------------------------------
  // stage a: clamp time to the duration
  // --------------------------------------------------------------------------
  logic             a_vld_q;
  logic [DUR_W-1:0] a_rem_q;
  sside_t           a_side_q;
  logic             t_eq;

  // t >= T means the clamped sample sits at the end, s = 1.0
  assign t_eq = sample_time_i[DUR_W-1:0] >= teff;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_rem_q      <= t_eq ? '0 : sample_time_i[DUR_W-1:0];
      a_side_q.neg <= sample_time_i[DATA_W-1];
      a_side_q.eq  <= t_eq;
    end
  end

  // --------------------------------------------------------------------------
  // s = t * 2^30 / T over 30 divider stages (t < T, so only fraction bits)
  // --------------------------------------------------------------------------
  logic          sd_vld;
  logic [QS-1:0] sd_quo;
  sside_t        sd_side;

  mjt_div #(
    .DW (DUR_W),
    .QW (QS),
    .SW ($bits(sside_t))
  ) u_sdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (a_vld_q),
    .rem_i     (a_rem_q),
    .num_i     ({QS{1'b0}}),
    .side_i    (a_side_q),
    .divisor_i (teff),
    .valid_o   (sd_vld),
    .quo_o     (sd_quo),
    .side_o    (sd_side)
  );

  // --------------------------------------------------------------------------
  // polynomial stages b..f
  // --------------------------------------------------------------------------
  logic b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q;
  logic b_neg_q, c_neg_q, d_neg_q, e_neg_q, f_neg_q;

  // b: s and u = 1 - s
  logic [S_W-1:0] b_s_q, b_u_q, s_b;
  assign s_b = sd_side.eq ? ONE_QS : {1'b0, sd_quo};

  // c: s^2 and u^2
  logic [S_W-1:0]   c_s_q, c_s2_q, c_u2_q;
  logic [2*S_W-1:0] ss_c, uu_c;
  assign ss_c = b_s_q * b_s_q;
  assign uu_c = b_u_q * b_u_q;

  // d: s^3, s^2 u^2 and the inner term 10 - 15 s + 6 s^2
  logic [S_W-1:0]     d_s3_q, d_w_q;
  logic [INNER_W-1:0] d_inner_q;
  logic [2*S_W-1:0]   s3_d, w_d;
  logic [INNER_W:0]   inner_d;
  assign s3_d    = c_s2_q * c_s_q;
  assign w_d     = c_s2_q * c_u2_q;
  assign inner_d = ((INNER_W+1)'(10) << QS)
                 + ((INNER_W+1)'(c_s2_q) << 2) + ((INNER_W+1)'(c_s2_q) << 1)
                 - ((INNER_W+1)'(c_s_q) << 4) + (INNER_W+1)'(c_s_q);

  // e: s^3 * inner as two partial products, speed shape q = 30 * w
  logic [PL_W-1:0] e_pl_q;
  logic [PH_W-1:0] e_ph_q;
  logic [S_W-1:0]  e_q_q;
  logic [S_W+4:0]  q_e;
  assign q_e = ((S_W+5)'(d_w_q) << 5) - ((S_W+5)'(d_w_q) << 1);

  // f: blend p = s^3 * inner >> 30
  logic [S_W-1:0]          f_p_q, f_q_q;
  logic [PH_W+INNER_LO:0]  sum_f;
  assign sum_f = {1'b0, e_ph_q, {INNER_LO{1'b0}}} + (PH_W+INNER_LO+1)'(e_pl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= sd_vld;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_s_q     <= s_b;
      b_u_q     <= ONE_QS - s_b;
      b_neg_q   <= sd_side.neg;

      c_s_q     <= b_s_q;
      c_s2_q    <= ss_c[QS+S_W-1:QS];
      c_u2_q    <= uu_c[QS+S_W-1:QS];
      c_neg_q   <= b_neg_q;

      d_s3_q    <= s3_d[QS+S_W-1:QS];
      d_w_q     <= w_d[QS+S_W-1:QS];
      d_inner_q <= inner_d[INNER_W-1:0];
      d_neg_q   <= c_neg_q;

      e_pl_q    <= d_s3_q * d_inner_q[INNER_LO-1:0];
      e_ph_q    <= d_s3_q * d_inner_q[INNER_W-1:INNER_LO];
      e_q_q     <= q_e[S_W-1:0];
      e_neg_q   <= d_neg_q;

      f_p_q     <= sum_f[QS+S_W-1:QS];
      f_q_q     <= e_q_q;
      f_neg_q   <= e_neg_q;
    end
  end

  // --------------------------------------------------------------------------
  // per-axis stages g..i
  // --------------------------------------------------------------------------
  logic g_vld_q, h_vld_q, i_vld_q;
  logic g_neg_q, h_neg_q;

  // g: |D| * p and |D| * q
  logic [PP_W-1:0] g_pp_q [NAX];
  logic [PP_W-1:0] g_vp_q [NAX];

  // h: rounded position magnitude, velocity numerator with half divisor
  logic [PM_W-1:0] h_pm_q [NAX];
  logic [NV_W-1:0] h_nv_q [NAX];
  logic [NV_W-1:0] pm_h   [NAX];

  // i: signed position, divider setup with overflow check
  logic [VDW-1:0]  i_rem_q  [NAX];
  logic [VQW-1:0]  i_num_q  [NAX];
  vside_t          i_side_q [NAX];
  logic [PV_W-1:0] pv_i     [NAX];
  logic [VDW-1:0]  nhi_i    [NAX];
  logic [NAX-1:0]  ovf_i;

  for (genvar a = 0; a < NAX; a++) begin : g_axis_math
    assign pm_h[a]  = NV_W'(g_pp_q[a]) + HALF_QS;
    // start +/- magnitude in 35 bits
    assign pv_i[a]  = dneg_q[a]
                    ? {{(PV_W-DATA_W){start_q[a][DATA_W-1]}}, start_q[a]}
                      - {{(PV_W-PM_W){1'b0}}, h_pm_q[a]}
                    : {{(PV_W-DATA_W){start_q[a][DATA_W-1]}}, start_q[a]}
                      + {{(PV_W-PM_W){1'b0}}, h_pm_q[a]};
    // quotient needs more than 32 bits when the upper half reaches the divisor
    assign nhi_i[a] = VDW'(h_nv_q[a][NV_W-1:VQW]);
    assign ovf_i[a] = nhi_i[a] >= vdiv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
    end else if (adv) begin
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_neg_q <= f_neg_q;
      h_neg_q <= g_neg_q;
      for (int a = 0; a < NAX; a++) begin
        g_pp_q[a]       <= mag_q[a] * f_p_q;
        g_vp_q[a]       <= mag_q[a] * f_q_q;
        h_pm_q[a]       <= pm_h[a][QS+PM_W-1:QS];
        h_nv_q[a]       <= NV_W'(g_vp_q[a]) + NV_W'(vdiv >> 1);
        i_rem_q[a]      <= ovf_i[a] ? '0 : nhi_i[a];
        i_num_q[a]      <= h_nv_q[a][VQW-1:0];
        i_side_q[a].ok  <= ~h_neg_q;
        i_side_q[a].ovf <= ovf_i[a];
        i_side_q[a].pos <= sat_pos(pv_i[a]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // velocity magnitude = numerator / (T << (30 - FRAC_BITS)), 32 stages
  // --------------------------------------------------------------------------
  logic [NAX-1:0] vd_vld;
  logic [VQW-1:0] vd_quo  [NAX];
  vside_t         vd_side [NAX];

  for (genvar a = 0; a < NAX; a++) begin : g_vdiv
    mjt_div #(
      .DW (VDW),
      .QW (VQW),
      .SW ($bits(vside_t))
    ) u_vdiv (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .valid_i   (i_vld_q),
      .rem_i     (i_rem_q[a]),
      .num_i     (i_num_q[a]),
      .side_i    (i_side_q[a]),
      .divisor_i (vdiv),
      .valid_o   (vd_vld[a]),
      .quo_o     (vd_quo[a]),
      .side_o    (vd_side[a])
    );
  end

  // the three lanes move in lockstep
  assign last_vld = &vd_vld;

  // --------------------------------------------------------------------------
  // output register; a rejected sample reports zeros
  // --------------------------------------------------------------------------
  logic              ok_q;
  logic [DATA_W-1:0] pos_q [NAX];
  logic [DATA_W-1:0] vel_q [NAX];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= last_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      ok_q <= vd_side[0].ok;
      for (int a = 0; a < NAX; a++) begin
        pos_q[a] <= vd_side[a].ok ? vd_side[a].pos : '0;
        vel_q[a] <= vd_side[a].ok ? sat_vel(vd_quo[a], vd_side[a].ovf, dneg_q[a]) : '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];
  assign vel_x_o     = vel_q[0];
  assign vel_y_o     = vel_q[1];
  assign vel_z_o     = vel_q[2];

endmodule
